[hdl/utf8_to_utf16_decoder_defines.svh]
// Assertion helpers; expect clk and rst_n in the enclosing module.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

// Same-cycle implication.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/u8u16_pkg.sv]
`default_nettype none

package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_LEAD    = 2'd1,
    ST_BAD_CONT    = 2'd2,
    ST_UNENCODABLE = 2'd3
  } status_t;

  typedef struct packed {
    logic [20:0] code_unit;
    status_t     status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]  owed;
    logic [20:0] partial;
    logic        disc;
  } dec_state_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } dec_res_t;

  localparam logic [20:0] CP_SURR_START = 21'h00D800;
  localparam logic [20:0] CP_SURR_END   = 21'h00E000;
  localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
  localparam logic [20:0] CP_LIMIT      = 21'h110000;
  localparam logic [20:0] SURR_HI_BASE  = 21'h00D800;
  localparam logic [20:0] SURR_LO_BASE  = 21'h00DC00;

endpackage

`default_nettype wire

[hdl/u8u16_decode.sv]
`default_nettype none

module u8u16_decode (
  input  wire logic                  utf32,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  eos,
  input  wire u8u16_pkg::dec_state_t st,
  output u8u16_pkg::dec_state_t      st_nxt,
  output u8u16_pkg::dec_res_t        res
);
  import u8u16_pkg::*;

  logic        do_emit;
  logic        do_fail;
  status_t     fail_st;
  logic [20:0] emit_code;
  logic [20:0] cont_code;
  logic [20:0] code_off;
  logic        unenc;

  assign cont_code = {st.partial[14:0], in_byte[5:0]};
  assign emit_code = (st.owed == 2'd0) ? {13'd0, in_byte} : cont_code;
  assign code_off  = emit_code - CP_SUPP_BASE;
  assign unenc     = ((emit_code >= CP_SURR_START) && (emit_code < CP_SURR_END)) ||
                     (emit_code >= CP_LIMIT);

  always_comb begin
    st_nxt    = st;
    res       = '0;
    do_emit   = 1'b0;
    do_fail   = 1'b0;
    fail_st   = ST_OK;

    if (st.disc) begin
      if (eos) st_nxt.disc = 1'b0;
    end else if (st.owed == 2'd0) begin
      if (!in_byte[7]) begin
        do_emit   = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        st_nxt.partial = {16'd0, in_byte[4:0]};
        st_nxt.owed    = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        st_nxt.partial = {17'd0, in_byte[3:0]};
        st_nxt.owed    = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        st_nxt.partial = {18'd0, in_byte[2:0]};
        st_nxt.owed    = 2'd3;
      end else begin
        do_fail = 1'b1;
        fail_st = ST_BAD_LEAD;
      end
      if (in_byte[7] && !do_fail && eos) begin
        do_fail = 1'b1;
        fail_st = ST_BAD_CONT;
      end
    end else if (in_byte[7:6] != 2'b10) begin
      do_fail = 1'b1;
      fail_st = ST_BAD_CONT;
    end else if (st.owed == 2'd1) begin
      do_emit   = 1'b1;
    end else if (eos) begin
      do_fail = 1'b1;
      fail_st = ST_BAD_CONT;
    end else begin
      st_nxt.partial = cont_code;
      st_nxt.owed    = st.owed - 2'd1;
    end

    if (do_emit) begin
      st_nxt.owed    = 2'd0;
      st_nxt.partial = '0;
      if (utf32) begin
        res.v0           = 1'b1;
        res.r0.code_unit = emit_code;
        res.r0.status    = ST_OK;
        res.r0.last      = eos;
      end else if (unenc) begin
        do_fail = 1'b1;
        fail_st = ST_UNENCODABLE;
      end else if (emit_code < CP_SUPP_BASE) begin
        res.v0           = 1'b1;
        res.r0.code_unit = emit_code;
        res.r0.status    = ST_OK;
        res.r0.last      = eos;
      end else begin
        res.v0           = 1'b1;
        res.v1           = 1'b1;
        res.r0.code_unit = SURR_HI_BASE | {11'd0, code_off[19:10]};
        res.r0.status    = ST_OK;
        res.r0.last      = 1'b0;
        res.r1.code_unit = SURR_LO_BASE | {11'd0, code_off[9:0]};
        res.r1.status    = ST_OK;
        res.r1.last      = eos;
      end
    end

    if (do_fail) begin
      st_nxt.owed      = 2'd0;
      st_nxt.partial   = '0;
      st_nxt.disc      = !eos;
      res.v0           = 1'b1;
      res.v1           = 1'b0;
      res.r0.code_unit = '0;
      res.r0.status    = fail_st;
      res.r0.last      = 1'b1;
      res.r1           = '0;
    end
  end

endmodule

`default_nettype wire

[hdl/u8u16_out_stage.sv]
`default_nettype none
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire u8u16_pkg::dec_res_t dec,
  output logic                     free,
  output logic                     out_vld,
  output u8u16_pkg::res_t          out_res,
  input  wire logic                out_rdy
);
  import u8u16_pkg::*;

  logic out_vld_r;
  res_t out_r;
  logic pend_r;
  res_t pend_data_r;
  logic slot_open;

  assign slot_open = !out_vld_r || out_rdy;
  assign free      = !pend_r && slot_open;
  assign out_vld   = out_vld_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else if (pend_r && slot_open) begin
      out_vld_r <= 1'b1;
      pend_r    <= 1'b0;
    end else if (take) begin
      out_vld_r <= dec.v0;
      pend_r    <= dec.v1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && slot_open) begin
      out_r <= pend_data_r;
    end else if (take) begin
      out_r       <= dec.r0;
      pend_data_r <= dec.r1;
    end
  end

  `U8U16_ASSERT_NOW(a_pend_behind_word, pend_r, out_vld_r, "pending low surrogate without a held word")
  `U8U16_ASSERT_NOW(a_pend_high_surr, pend_r,
    (!out_r.last && (out_r.code_unit[20:10] == 11'h036)),
    "word ahead of pending unit is not a high surrogate")
  `U8U16_ASSERT_NEXT(a_pend_drains, (pend_r && out_vld_r && out_rdy),
    (out_vld_r && !pend_r), "pending unit not moved into output register")

endmodule

`default_nettype wire

[hdl/utf8_to_utf16_decoder.sv]
// UTF-8 to UTF-16 / UTF-32 transcoder.
// in_*  : stream of UTF-8 bytes, one per word; in_tlast marks the final byte of a string.
// out_* : one code unit per word; out_tuser carries the status (0 ok, 1 bad lead byte,
//         2 bad or missing continuation, 3 unencodable); out_tlast marks the last word of
//         a string, error words included. Error words carry a zero code unit.
// cfg_* : one-bit mode write, 0 = UTF-16 with surrogate pairs, 1 = whole code points.
//         Write only while no string is in flight; cfg_ready is always high.
// Path: an accepted byte is decoded from the input register, and its first word is
// loaded into the output register, where it is offered, when the byte is taken.
// Throughput: one byte per cycle while the output register drains. A surrogate pair is
// sent as two words; the input register holds the next byte until the second is loaded.
// An error ends the string; bytes are dropped up to and including the next in_tlast byte.
// When out_tready is low, the output register holds its word and the input register
// holds one byte, then in_tready falls.
// Reset (rst_n low, synchronous) clears the input, output and pending valid flags, the decode state and the mode.
`default_nettype none

module utf8_to_utf16_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_unit, [23:21] zero
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import u8u16_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;
  logic       utf32_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  dec_res_t   dec;
  logic       free;
  logic       take;
  res_t       out_res;

  assign take      = in_vld_r && free;
  assign in_tready = !in_vld_r || take;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf32_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      utf32_r <= cfg_data;
    end
  end

  u8u16_decode u_decode (
    .utf32   (utf32_r),
    .in_byte (in_byte_r),
    .eos     (in_eos_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (dec)
  );

  u8u16_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .dec     (dec),
    .free    (free),
    .out_vld (out_tvalid),
    .out_res (out_res),
    .out_rdy (out_tready)
  );

  assign out_tdata = {3'b000, out_res.code_unit};
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import u8u16_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] code_unit, [23:21] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  logic        utf32_mode;
  logic [1:0]  owed;
  logic [20:0] partial;
  logic        dropping;
  res_t        pending_units[$];
  logic [7:0]  text_buf[$];
  int          mismatches;
  int          bytes_sent;
  int          burst_left;
  bit          offering;
  bit          gaps_on;
  bit          hold_req;

  utf8_to_utf16_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void push_unit(logic [20:0] cu, status_t st, logic lst);
    res_t u;
    u.code_unit = cu;
    u.status    = st;
    u.last      = lst;
    pending_units.push_back(u);
  endfunction

  function automatic void push_fail(status_t st, logic eos);
    owed     = 2'd0;
    partial  = 21'd0;
    dropping = !eos;
    push_unit(21'd0, st, 1'b1);
  endfunction

  function automatic void push_code(logic [20:0] cp, logic eos);
    logic [20:0] off;
    owed    = 2'd0;
    partial = 21'd0;
    off     = cp - CP_SUPP_BASE;
    if (utf32_mode) begin
      push_unit(cp, ST_OK, eos);
    end else if ((cp >= CP_SURR_START && cp < CP_SURR_END) || cp >= CP_LIMIT) begin
      push_fail(ST_UNENCODABLE, eos);
    end else if (cp < CP_SUPP_BASE) begin
      push_unit(cp, ST_OK, eos);
    end else begin
      push_unit(SURR_HI_BASE + {11'd0, off[19:10]}, ST_OK, 1'b0);
      push_unit(SURR_LO_BASE + {11'd0, off[9:0]}, ST_OK, eos);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eos);
    if (dropping) begin
      if (eos) dropping = 1'b0;
      return;
    end
    if (owed == 2'd0) begin
      if (!b[7]) begin
        push_code({13'd0, b}, eos);
        return;
      end
      if (b[7:5] == 3'b110) begin
        partial = {16'd0, b[4:0]};
        owed    = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial = {17'd0, b[3:0]};
        owed    = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial = {18'd0, b[2:0]};
        owed    = 2'd3;
      end else begin
        push_fail(ST_BAD_LEAD, eos);
        return;
      end
      if (eos) push_fail(ST_BAD_CONT, eos);
      return;
    end
    if (b[7:6] != 2'b10) begin
      push_fail(ST_BAD_CONT, eos);
      return;
    end
    partial = {partial[14:0], b[5:0]};
    owed    = owed - 2'd1;
    if (owed == 2'd0) push_code(partial, eos);
    else if (eos) push_fail(ST_BAD_CONT, eos);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && offering) begin
        in_tvalid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_units.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    utf32_mode = m;
  endtask

  function automatic void append_char(int len);
    logic [7:0] r;
    r = $urandom;
    case (len)
      1: text_buf.push_back({1'b0, r[6:0]});
      2: text_buf.push_back({3'b110, r[4:0]});
      3: text_buf.push_back({4'b1110, r[3:0]});
      default: text_buf.push_back({5'b11110, r[2:0]});
    endcase
    for (int i = 1; i < len; i++) begin
      r = $urandom;
      text_buf.push_back({2'b10, r[5:0]});
    end
  endfunction

  function automatic void build_text(bit well_formed);
    int nchars;
    int pick;
    int cut;
    nchars = $urandom_range(1, 6);
    for (int i = 0; i < nchars; i++) append_char($urandom_range(1, 4));
    pick = well_formed ? 0 : $urandom_range(0, 9);
    if (pick == 7) begin
      text_buf.delete();
      cut = $urandom_range(1, 8);
      for (int i = 0; i < cut; i++) text_buf.push_back(8'($urandom));
    end else if (pick == 8 && text_buf.size() > 1) begin
      cut = $urandom_range(1, 2);
      for (int i = 0; i < cut && text_buf.size() > 1; i++) void'(text_buf.pop_back());
    end else if (pick == 9) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
    end
  endfunction

  // receiver: stall patterns, plus a long hold on request
  initial begin
    int style;
    int style_left;
    style_left = 0;
    style = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        if (style_left <= 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_words
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual code %h status %0d last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = pending_units.pop_front();
        if (out_tdata !== {3'b000, want.code_unit}) begin
          $display("%0t: code_unit expected %h actual %h", $time, want.code_unit, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  task automatic test_utf16_directed();
    write_mode(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hE2, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_utf32_directed();
    write_mode(1'b1);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_random_text(input logic m, input int n_bytes);
    int target;
    write_mode(m);
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_text(($urandom_range(0, 9) < 7));
      send_text();
    end
  endtask

  task automatic test_output_hold(input logic m);
    write_mode(m);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      build_text(1'b1);
      send_text();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'd0;
    in_tlast   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= 1'b0;
    utf32_mode = 1'b0;
    owed       = 2'd0;
    partial    = 21'd0;
    dropping   = 1'b0;
    mismatches = 0;
    bytes_sent = 0;
    burst_left = 0;
    offering   = 1'b0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_utf16_directed();
    test_utf32_directed();
    test_random_text(1'b0, 550);
    test_random_text(1'b1, 400);
    test_output_hold(1'b1);
    test_random_text(1'b0, 350);
    test_output_hold(1'b0);
    wait_idle();

    if (pending_units.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_units.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[utf8_to_utf16_decoder.f]
+incdir+hdl
hdl/u8u16_pkg.sv
hdl/u8u16_decode.sv
hdl/u8u16_out_stage.sv
hdl/utf8_to_utf16_decoder.sv
dv/tb_top.sv
